[rtl/csm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex sample magnitude package
// Shared widths, payload types and the square-root pipeline record.
// ----------------------------------------------------------------------------
package csm_pkg;

   // Width of one signed sample component.
   localparam int SAMPLE_BITS = 16;

   // Sum of squares, padded to an even number of bits for the square root.
   localparam int RADICAND_BITS = 2 * SAMPLE_BITS + 2;

   // One square-root stage per pair of radicand bits.
   localparam int SQRT_STAGES = RADICAND_BITS / 2;

   // Partial root and partial remainder both fit in one bit more than a sample.
   localparam int ROOT_BITS = SAMPLE_BITS + 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] real_part;
      logic signed [SAMPLE_BITS-1:0] imag_part;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] real_out;
      logic signed [SAMPLE_BITS-1:0] imag_out;
      logic [SAMPLE_BITS-1:0]        magnitude;
   } rsp_payload_type;

   typedef struct packed {
      logic [RADICAND_BITS-1:0] radicand;
      logic [ROOT_BITS-1:0]     rem;
      logic [ROOT_BITS-1:0]     root;
      req_payload_type          sample;
   } sqrt_data_type;

endpackage

[rtl/csm_square.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sum of squares
// Three register stages: absolute values, squares, then their sum, which
// seeds the square-root pipeline.
// ----------------------------------------------------------------------------
module csm_square (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_in,
   input  csm_pkg::req_payload_type data_in,
   output logic                    valid_out,
   output csm_pkg::sqrt_data_type  data_out
);

   localparam int N = csm_pkg::SAMPLE_BITS;

   logic                      abs_valid_ff;
   logic [N-1:0]              abs_re_ff;
   logic [N-1:0]              abs_im_ff;
   csm_pkg::req_payload_type  abs_sample_ff;
   logic [N-1:0]              abs_re_in;
   logic [N-1:0]              abs_im_in;

   logic                      sq_valid_ff;
   logic [2*N-1:0]            sq_re_ff;
   logic [2*N-1:0]            sq_im_ff;
   csm_pkg::req_payload_type  sq_sample_ff;

   logic                      sum_valid_ff;
   csm_pkg::sqrt_data_type    sum_data_ff;
   csm_pkg::sqrt_data_type    sum_data_in;

   // The most negative code negates to itself, which read as unsigned is
   // exactly its magnitude.
   always_comb begin
      abs_re_in = data_in.real_part[N-1] ? (~data_in.real_part + 1'b1) : data_in.real_part;
      abs_im_in = data_in.imag_part[N-1] ? (~data_in.imag_part + 1'b1) : data_in.imag_part;
   end

   always_comb begin
      sum_data_in          = '0;
      sum_data_in.radicand = {2'b00, sq_re_ff} + {2'b00, sq_im_ff};
      sum_data_in.sample   = sq_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         abs_valid_ff <= valid_in;
         sq_valid_ff  <= abs_valid_ff;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_re_ff     <= abs_re_in;
         abs_im_ff     <= abs_im_in;
         abs_sample_ff <= data_in;
         sq_re_ff      <= abs_re_ff * abs_re_ff;
         sq_im_ff      <= abs_im_ff * abs_im_ff;
         sq_sample_ff  <= abs_sample_ff;
         sum_data_ff   <= sum_data_in;
      end
   end

   assign valid_out = sum_valid_ff;
   assign data_out  = sum_data_ff;

endmodule

[rtl/csm_sqrt_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-root stage
// One restoring step: brings down the next two radicand bits and settles
// one more bit of the root.
// ----------------------------------------------------------------------------
module csm_sqrt_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  csm_pkg::sqrt_data_type data_in,
   output logic                   valid_out,
   output csm_pkg::sqrt_data_type data_out
);

   localparam int RB = csm_pkg::ROOT_BITS;
   localparam int XB = csm_pkg::RADICAND_BITS;

   logic                   valid_ff;
   csm_pkg::sqrt_data_type data_ff;
   csm_pkg::sqrt_data_type data_in_next;
   logic [RB+1:0]          cand;
   logic [RB+1:0]          trial;
   logic [RB+1:0]          diff;
   logic                   fits;

   always_comb begin
      cand  = {data_in.rem, data_in.radicand[XB-1 -: 2]};
      trial = {data_in.root, 2'b01};
      diff  = cand - trial;
      fits  = (cand >= trial);

      data_in_next          = data_in;
      data_in_next.radicand = {data_in.radicand[XB-3:0], 2'b00};
      data_in_next.rem      = fits ? diff[RB-1:0] : cand[RB-1:0];
      data_in_next.root     = {data_in.root[RB-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

[rtl/complex_sample_magnitude.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex sample magnitude
// Passes a complex sample through and adds sqrt(re^2 + im^2) rounded half up.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle while req_stall is low.
// Three stages form the sum of squares, seventeen restoring square-root
// stages each settle one root bit, and the output register applies the
// rounding from the final remainder.
// The whole pipeline holds while a waiting result is stalled, so req_stall
// follows rsp_stall whenever a result is on offer.
// ----------------------------------------------------------------------------
module complex_sample_magnitude (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  csm_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output csm_pkg::rsp_payload_type rsp_payload
);

   localparam int N  = csm_pkg::SAMPLE_BITS;
   localparam int NS = csm_pkg::SQRT_STAGES;
   localparam int RB = csm_pkg::ROOT_BITS;

   logic                     advance;
   logic                     stage_valid [0:NS];
   csm_pkg::sqrt_data_type   stage_data  [0:NS];

   logic                     rsp_valid_ff;
   csm_pkg::rsp_payload_type rsp_payload_ff;
   csm_pkg::rsp_payload_type rsp_payload_in;
   logic [RB-1:0]            rounded;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   csm_square u_square (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (req_valid),
      .data_in   (req_payload),
      .valid_out (stage_valid[0]),
      .data_out  (stage_data[0])
   );

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      csm_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (stage_valid[i]),
         .data_in   (stage_data[i]),
         .valid_out (stage_valid[i+1]),
         .data_out  (stage_data[i+1])
      );
   end

   // Rounding half up: x - s*s is the remainder, so x > s*s + s exactly
   // when the remainder exceeds the root.
   always_comb begin
      rounded = stage_data[NS].root + RB'(stage_data[NS].rem > stage_data[NS].root);
      rsp_payload_in.real_out  = stage_data[NS].sample.real_part;
      rsp_payload_in.imag_out  = stage_data[NS].sample.imag_part;
      rsp_payload_in.magnitude = rounded[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[tb/complex_sample_magnitude_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex sample magnitude testbench
// Sends complex samples through the magnitude pipeline and checks every
// result against an exact square root rounded half up, with random gaps on the input
// side and random stalls on the output side.
// ----------------------------------------------------------------------------
module complex_sample_magnitude_tb;

   localparam int SAMPLE_BITS = csm_pkg::SAMPLE_BITS;
   localparam int ROOT_BITS = csm_pkg::ROOT_BITS;
   localparam int RADICAND_BITS = csm_pkg::RADICAND_BITS;

   typedef struct packed {
      csm_pkg::req_payload_type sample;
      logic                     known;       // magnitude below is given, not predicted
      logic [SAMPLE_BITS-1:0]   magnitude;
   } sample_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_SAMPLES = 1630;
   localparam int LONG_HOLD_CYCLES = 250;

   localparam sample_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{16'sh0000, 16'sh0000}, 1'b1, 16'd0},
      '{'{16'sh8000, 16'sh8000}, 1'b1, 16'd46341},
      '{'{16'sh7FFF, 16'sh7FFF}, 1'b0, 16'd0},
      '{'{16'sh8000, 16'sh0000}, 1'b1, 16'd32768},
      '{'{16'sh0000, 16'sh8000}, 1'b1, 16'd32768},
      '{'{16'sh0000, 16'sh7FFF}, 1'b1, 16'd32767},
      '{'{16'sh7FFF, 16'sh0000}, 1'b1, 16'd32767},
      '{'{16'sh7FFF, 16'sh8000}, 1'b0, 16'd0},
      '{'{16'sh8000, 16'sh7FFF}, 1'b0, 16'd0},
      '{'{16'shFFFF, 16'shFFFF}, 1'b0, 16'd0},
      '{'{16'sh0001, 16'sh0000}, 1'b1, 16'd1},
      '{'{16'sh0003, 16'sh0004}, 1'b1, 16'd5},
      '{'{16'shFFFD, 16'shFFFC}, 1'b1, 16'd5},
      '{'{16'sh0004, 16'sh0002}, 1'b0, 16'd0},
      '{'{16'sh0002, 16'sh0003}, 1'b0, 16'd0},
      '{'{16'sh0001, 16'sh0001}, 1'b0, 16'd0},
      '{'{16'sh8001, 16'sh8001}, 1'b0, 16'd0},
      '{'{16'sh5555, 16'shAAAA}, 1'b0, 16'd0},
      '{'{16'shAAAA, 16'sh5555}, 1'b0, 16'd0},
      '{'{16'shFFFF, 16'sh0000}, 1'b1, 16'd1}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   csm_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   csm_pkg::rsp_payload_type rsp_payload;

   csm_pkg::rsp_payload_type pending_results[$];
   int unsigned              mismatch_count = 0;
   bit                       hold_results = 1'b0;

   complex_sample_magnitude uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Exact rounded magnitude: the root is built one bit at a time from the top,
   // then rounded up when the energy lies beyond s*s + s.
   function automatic csm_pkg::rsp_payload_type rounded_magnitude(
         input csm_pkg::req_payload_type s);
      logic [ROOT_BITS-1:0]     abs_re;
      logic [ROOT_BITS-1:0]     abs_im;
      logic [ROOT_BITS-1:0]     root;
      logic [ROOT_BITS-1:0]     trial;
      logic [RADICAND_BITS-1:0] energy;
      logic [RADICAND_BITS-1:0] square;
      csm_pkg::rsp_payload_type r;
      abs_re = s.real_part[SAMPLE_BITS-1] ? ~{1'b1, s.real_part} + 1'b1
                                          : {1'b0, s.real_part};
      abs_im = s.imag_part[SAMPLE_BITS-1] ? ~{1'b1, s.imag_part} + 1'b1
                                          : {1'b0, s.imag_part};
      energy = RADICAND_BITS'(abs_re) * RADICAND_BITS'(abs_re)
             + RADICAND_BITS'(abs_im) * RADICAND_BITS'(abs_im);
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         trial = root | (ROOT_BITS'(1) << b);
         square = RADICAND_BITS'(trial) * RADICAND_BITS'(trial);
         if (square <= energy) begin
            root = trial;
         end
      end
      square = RADICAND_BITS'(root) * RADICAND_BITS'(root) + RADICAND_BITS'(root);
      r.real_out = s.real_part;
      r.imag_out = s.imag_part;
      r.magnitude = SAMPLE_BITS'((energy > square) ? root + 1'b1 : root);
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] edge_value();
      logic [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 16'h8000;
         1: v = 16'h8001;
         2: v = 16'h7FFF;
         3: v = 16'hFFFF;
         4: v = 16'h0001;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

   // Mostly full-range samples, with small values and full-scale corners mixed in.
   function automatic csm_pkg::req_payload_type random_sample();
      csm_pkg::req_payload_type s;
      int unsigned              kind;
      kind = $urandom_range(0, 9);
      s = csm_pkg::req_payload_type'($urandom);
      if (kind == 6 || kind == 7) begin
         s.real_part = SAMPLE_BITS'($urandom_range(0, 32)) - 16'sd16;
         s.imag_part = SAMPLE_BITS'($urandom_range(0, 32)) - 16'sd16;
      end else if (kind == 8) begin
         s.real_part = edge_value();
         s.imag_part = edge_value();
      end else if (kind == 9) begin
         s.real_part = edge_value();
      end
      return s;
   endfunction

   function automatic int unsigned sender_gap(input int idx);
      if ((idx / 64) % 3 == 1) begin
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // Offers one request and records its expected result once it is taken.
   task automatic send_sample(input csm_pkg::req_payload_type s,
                              input csm_pkg::rsp_payload_type want,
                              input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(want);
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      csm_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result re=%0d im=%0d mag=%0d", $time,
                     rsp_payload.real_out, rsp_payload.imag_out, rsp_payload.magnitude);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.real_out !== want.real_out) begin
               $display("%0t: real_out expected %0d, got %0d", $time,
                        want.real_out, rsp_payload.real_out);
               mismatch_count++;
            end
            if (rsp_payload.imag_out !== want.imag_out) begin
               $display("%0t: imag_out expected %0d, got %0d", $time,
                        want.imag_out, rsp_payload.imag_out);
               mismatch_count++;
            end
            if (rsp_payload.magnitude !== want.magnitude) begin
               $display("%0t: magnitude expected %0d, got %0d (re=%0d im=%0d)", $time,
                        want.magnitude, rsp_payload.magnitude,
                        want.real_out, want.imag_out);
               mismatch_count++;
            end
         end
      end
   end

   // Result side: random stalls, spells with none, and one long hold-off.
   initial begin
      int unsigned taken;
      int unsigned hold;
      taken = 0;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_results) begin
            hold = LONG_HOLD_CYCLES;
            hold_results = 1'b0;
         end else if ((taken / 50) % 4 == 2) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 18);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      csm_pkg::rsp_payload_type want;
      csm_pkg::req_payload_type s;
      int unsigned              gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         want = rounded_magnitude(DIRECTED[i].sample);
         if (DIRECTED[i].known) begin
            want.magnitude = DIRECTED[i].magnitude;
         end
         send_sample(DIRECTED[i].sample, want, $urandom_range(0, 3));
      end

      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         // Hold the sender back until the pipeline has emptied completely.
         if (i == 200 || i == 900) begin
            req_valid <= 1'b0;
            drain_results();
            @(posedge clock);
         end
         if (i == 400) begin
            hold_results = 1'b1;
         end
         gap = (i >= 400 && i < 500) ? 0 : sender_gap(i);
         s = random_sample();
         send_sample(s, rounded_magnitude(s), gap);
      end
      req_valid <= 1'b0;

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("complex_sample_magnitude_tb passed");
      end else begin
         $display("complex_sample_magnitude_tb failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("complex_sample_magnitude_tb failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/csm_pkg.sv
rtl/csm_square.sv
rtl/csm_sqrt_stage.sv
rtl/complex_sample_magnitude.sv
tb/complex_sample_magnitude_tb.sv
